// ===== rtl/decimal_seven_segment_scan_defines.svh =====
// ----------------------------------------------------------------------------
// decimal seven-segment scan: assertion macros
// shared concurrent assertion forms, clocked on i_clk, off during reset
// ----------------------------------------------------------------------------
`ifndef DECIMAL_SEVEN_SEGMENT_SCAN_DEFINES_SVH
`define DECIMAL_SEVEN_SEGMENT_SCAN_DEFINES_SVH

// same-cycle implication
`define DSS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define DSS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/dss_pkg.sv =====
// ----------------------------------------------------------------------------
// dss_pkg
// widths, constants and the segment decode for the decimal seven-segment scan
// ----------------------------------------------------------------------------
`default_nettype none

package dss_pkg;

    localparam int DIGIT_COUNT = 8;
    localparam int VALUE_W     = 32;
    localparam int DIGIT_W     = 4;
    localparam int BCD_W       = DIGIT_COUNT * DIGIT_W;
    localparam int STEP_W      = $clog2(VALUE_W);
    localparam int POS_W       = 3;
    localparam int SEG_W       = 7;

    localparam logic [STEP_W-1:0] LAST_STEP     = STEP_W'(VALUE_W - 1);
    localparam logic [POS_W-1:0]  ONES_POSITION = 3'd7;

    typedef struct packed {
        logic start;
    } t_conv_ctrl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_conv_stat;

    // common-cathode pattern, bit0 segment a to bit6 segment g
    function automatic logic [SEG_W-1:0] seg_code(input logic [DIGIT_W-1:0] digit);
        logic [SEG_W-1:0] code;
        case (digit)
            4'd0:    code = 7'h3F;
            4'd1:    code = 7'h06;
            4'd2:    code = 7'h5B;
            4'd3:    code = 7'h4F;
            4'd4:    code = 7'h66;
            4'd5:    code = 7'h6D;
            4'd6:    code = 7'h7D;
            4'd7:    code = 7'h07;
            4'd8:    code = 7'h7F;
            4'd9:    code = 7'h6F;
            default: code = 7'h00;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/dss_if.sv =====
// ----------------------------------------------------------------------------
// dss interfaces
// valid/ready channels for the number request and the digit results
// ----------------------------------------------------------------------------
`default_nettype none

interface dss_in_if;
    logic                         valid;
    logic                         ready;
    logic [dss_pkg::VALUE_W-1:0]  value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface dss_out_if;
    logic                         valid;
    logic                         ready;
    logic [dss_pkg::POS_W-1:0]    digit_position;
    logic [dss_pkg::SEG_W-1:0]    segment_pattern;
    logic                         last_digit;

    modport source (output valid, output digit_position, output segment_pattern,
                    output last_digit, input ready);
    modport sink   (input valid, input digit_position, input segment_pattern,
                    input last_digit, output ready);
endinterface

`default_nettype wire

// ===== rtl/decimal_seven_segment_scan.sv =====
// ----------------------------------------------------------------------------
// decimal_seven_segment_scan
// splits a number into decimal digits and sends one segment code per
// significant digit, ones digit first at tube position 7
// ----------------------------------------------------------------------------
//  channel  dir  payload                                        width
//  i_in     in   value                                          32
//  o_out    out  digit_position, segment_pattern, last_digit    3, 7, 1
//
//  an item with n = 1..8 significant digits runs in order: take the request,
//  run the bit-serial bcd conversion over the 32 input bits, load the digits,
//  then one digit into the output register per cycle while the output is not stalled
//  the next request is taken once the last digit sits in the output register
//  a stalled output holds the register and pauses the digit sequence
//  reset is synchronous and clears the sequencer and output valid
// ----------------------------------------------------------------------------
`default_nettype none
`include "decimal_seven_segment_scan_defines.svh"

module decimal_seven_segment_scan (
    input  wire         i_clk,
    input  wire         i_rst_n,
    dss_in_if.sink      i_in,
    dss_out_if.source   o_out
);
    import dss_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]       r_state;
    logic [BCD_W-1:0] r_digits;
    logic [POS_W-1:0] r_pos;
    logic             r_out_valid;
    logic [POS_W-1:0] r_out_pos;
    logic [SEG_W-1:0] r_out_seg;
    logic             r_out_last;

    t_conv_ctrl       conv_ctrl;
    t_conv_stat       conv_stat;
    logic [BCD_W-1:0] conv_bcd;

    logic             n_accept;
    logic             n_load;
    logic             n_last;
    logic [BCD_W-1:0] n_rest;

    assign n_accept        = i_in.valid && i_in.ready;
    assign conv_ctrl.start = n_accept;
    assign n_load          = (r_state == ST_EMIT) && (!r_out_valid || o_out.ready);
    assign n_rest          = r_digits >> DIGIT_W;
    assign n_last          = (n_rest == '0);

    dss_converter u_conv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (conv_ctrl),
        .i_value (i_in.value),
        .o_stat  (conv_stat),
        .o_bcd   (conv_bcd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (o_out.valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (n_accept) begin
                        r_state <= ST_CONV;
                    end
                end
                ST_CONV: begin
                    if (conv_stat.done) begin
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (n_load) begin
                        r_out_valid <= 1'b1;
                        if (n_last) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_CONV && conv_stat.done) begin
            r_digits <= conv_bcd;
            r_pos    <= ONES_POSITION;
        end else if (n_load) begin
            r_digits   <= n_rest;
            r_pos      <= r_pos - 1'b1;
            r_out_pos  <= r_pos;
            r_out_seg  <= seg_code(r_digits[DIGIT_W-1:0]);
            r_out_last <= n_last;
        end
    end

    assign i_in.ready            = (r_state == ST_IDLE);
    assign o_out.valid           = r_out_valid;
    assign o_out.digit_position  = r_out_pos;
    assign o_out.segment_pattern = r_out_seg;
    assign o_out.last_digit      = r_out_last;

    `DSS_ASSERT_NOW(a_done_in_conv, conv_stat.done, r_state == ST_CONV, "conversion done out of turn")
    `DSS_ASSERT_NEXT(a_accept_conv, n_accept, r_state == ST_CONV && conv_stat.busy, "request not converting")
    `DSS_ASSERT_NEXT(a_last_idle, n_load && n_last, r_state == ST_IDLE && r_out_valid && r_out_last, "last digit not flagged")

endmodule

`default_nettype wire

// ===== rtl/dss_converter.sv =====
// ----------------------------------------------------------------------------
// dss_converter
// shift-and-add-3 binary to bcd, one input bit per cycle, kept modulo the
// number of display digits
// ----------------------------------------------------------------------------
`default_nettype none
`include "decimal_seven_segment_scan_defines.svh"

module dss_converter (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  dss_pkg::t_conv_ctrl          i_ctrl,
    input  wire [dss_pkg::VALUE_W-1:0]   i_value,
    output dss_pkg::t_conv_stat          o_stat,
    output logic [dss_pkg::BCD_W-1:0]    o_bcd
);
    import dss_pkg::*;

    logic [VALUE_W-1:0] r_bin;
    logic [BCD_W-1:0]   r_bcd;
    logic [STEP_W-1:0]  r_cnt;
    logic               r_busy;
    logic               r_done;

    logic [BCD_W-1:0]   n_adj;
    logic [BCD_W-1:0]   n_bcd;
    logic [VALUE_W-1:0] n_bin;

    always_comb begin
        for (int d = 0; d < DIGIT_COUNT; d++) begin
            if (r_bcd[d*DIGIT_W +: DIGIT_W] >= 4'd5) begin
                n_adj[d*DIGIT_W +: DIGIT_W] = r_bcd[d*DIGIT_W +: DIGIT_W] + 4'd3;
            end else begin
                n_adj[d*DIGIT_W +: DIGIT_W] = r_bcd[d*DIGIT_W +: DIGIT_W];
            end
        end
        // top digit carry drops out: result stays modulo ten to the digit count
        n_bcd = {n_adj[BCD_W-2:0], r_bin[VALUE_W-1]};
        n_bin = {r_bin[VALUE_W-2:0], 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctrl.start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.start && !r_busy) begin
            r_bin <= i_value;
            r_bcd <= '0;
        end else if (r_busy) begin
            r_bin <= n_bin;
            r_bcd <= n_bcd;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_bcd       = r_bcd;

    `DSS_ASSERT_NEXT(a_start_busy, i_ctrl.start && !r_busy, r_busy, "start did not begin conversion")
    `DSS_ASSERT_NOW(a_done_idle, r_done, !r_busy, "done while still converting")
    `DSS_ASSERT_NEXT(a_last_done, r_busy && r_cnt == LAST_STEP, r_done && !r_busy, "missing done")
    `DSS_ASSERT_NOW(a_start_free, i_ctrl.start, !r_busy, "start while busy")

endmodule

`default_nettype wire
